// ===== rtl/pc_line_table_encoder_assert.svh =====
// Assertion helpers used by the checker file.
`ifndef PC_LINE_TABLE_ENCODER_ASSERT_SVH
`define PC_LINE_TABLE_ENCODER_ASSERT_SVH

// same-cycle implication, masked during reset
`define PLTE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define PLTE_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, live through reset
`define PLTE_ASSERT_RST(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/plte_pkg.sv =====
`default_nettype none

package plte_pkg;

    localparam int MIN_INSTR_BYTES   = 4;
    localparam int MAX_ADVANCE_BYTES = 59;

    // advance byte carries 1..ADV_STEP units
    localparam int ADV_STEP = 127;
    localparam int ADV_BASE = 128;
    localparam int ADV_MAX  = MAX_ADVANCE_BYTES * ADV_STEP;
    localparam int ADV_W    = $clog2(ADV_MAX + 1);

    localparam int SHORT_MAX = 64;
    localparam int PAD_BYTE  = 129;
    localparam int LONG_ESC  = 0;

    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_RECORD = 2'd1,
        REQ_FINISH = 2'd2
    } t_req;

endpackage

`default_nettype wire

// ===== rtl/plte_alu.sv =====
`default_nettype none

// Shared 32-bit subtractor: diff = a - b, borrow set when a < b (unsigned).
module plte_alu (
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [31:0] o_diff,
    output logic             o_borrow
);

    logic [32:0] w_full;

    assign w_full   = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = w_full[31:0];
    assign o_borrow = w_full[32];

endmodule

`default_nettype wire

// ===== rtl/pc_line_table_encoder.sv =====
// pc_line_table_encoder: builds a pc/line table as a byte stream.
// Input channel (s): one item per request. tuser = req_type (start, record,
//   finish); tdata = {skip, src_line, instr_pc}. Output channel (m): one byte per
//   item, tlast on the final byte caused by an input item, tuser = overflow.
// Config: i_cfg_we/i_cfg_wdata load text_base, used by the next start item.
// Sequence: a start item, an unknown code, a skipped record or a record on
//   the same line emit nothing. A finish emits the pad byte when the byte
//   parity is odd. A line-change record steps through accept, pc difference,
//   k advance bytes (one per cycle unless stalled, ceil(units/127)), line
//   delta, d delta bytes (1 or 5). All three arithmetic steps go through a
//   single shared subtractor, which sets the pace: at most one byte per cycle.
// Each byte appears on the output register the cycle after it is produced.
// Ready is high only while the sequencer is idle.
// Receiver stall: the sequencer holds in its byte-emitting states while the output register is full and
//   not taken; nothing is dropped and the output payload stays put.
// Reset (i_rst_n low, synchronous): sequencer idle, output empty, prev_pc,
//   prev_line, byte parity and text_base cleared.
`default_nettype none

module pc_line_table_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,   // text_base
    // input item stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,     // [31:0] instr_pc, [62:32] src_line, [63] skip
    input  wire logic [1:0]  i_s_tuser,     // [1:0] req_type
    // output byte stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,     // [7:0] out_byte
    output logic             o_m_tlast,
    output logic             o_m_tuser      // [0] overflow
);

    import plte_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PCDIFF,
        ST_ADV,
        ST_LDELTA,
        ST_EMIT,
        ST_PAD
    } t_state;

    // control
    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;
    logic   r_odd, n_odd;
    logic [31:0] r_text_base, n_text_base;
    logic [31:0] r_prev_pc, n_prev_pc;
    logic [30:0] r_prev_line, n_prev_line;

    // payload
    logic [31:0]      r_pc, n_pc;
    logic [30:0]      r_line, n_line;
    logic [ADV_W-1:0] r_units, n_units;
    logic             r_ovf, n_ovf;
    logic [31:0]      r_delta, n_delta;
    logic             r_long, n_long;
    logic [7:0]       r_short, n_short;
    logic [2:0]       r_idx, n_idx;
    logic [7:0]       r_m_data, n_m_data;
    logic             r_m_last, n_m_last;
    logic             r_m_user, n_m_user;

    // shared subtractor
    logic [31:0] w_alu_a, w_alu_b, w_diff;
    logic        w_borrow;

    logic        w_accept;
    logic        w_slot;
    logic        w_push;
    t_req        w_req;
    logic [31:0] w_in_pc;
    logic [30:0] w_in_line;
    logic        w_in_skip;
    logic [31:0] w_units_full;
    logic        w_adv_ovf;
    logic        w_adv_fin;
    logic        w_pos_small;
    logic        w_neg_small;
    logic [7:0]  w_long_byte;

    plte_alu u_alu (
        .i_a      (w_alu_a),
        .i_b      (w_alu_b),
        .o_diff   (w_diff),
        .o_borrow (w_borrow)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;
    assign o_m_tuser  = r_m_user;

    assign w_accept  = i_s_tvalid && o_s_tready;
    assign w_slot    = !r_m_valid || i_m_tready;
    assign w_req     = t_req'(i_s_tuser);
    assign w_in_pc   = i_s_tdata[31:0];
    assign w_in_line = i_s_tdata[62:32];
    assign w_in_skip = i_s_tdata[63];

    // operand select for the shared subtractor
    always_comb begin
        unique case (r_state)
            ST_ADV: begin
                w_alu_a = 32'(r_units);
                w_alu_b = 32'(ADV_STEP);
            end
            ST_LDELTA: begin
                w_alu_a = {1'b0, r_line};
                w_alu_b = {1'b0, r_prev_line};
            end
            default: begin
                w_alu_a = r_pc;
                w_alu_b = r_prev_pc;
            end
        endcase
    end

    // pc step: units of instruction size, dropped past the advance bound
    assign w_units_full = w_diff / MIN_INSTR_BYTES;
    assign w_adv_ovf    = !w_borrow && (w_units_full > 32'(ADV_MAX));
    // advance step: last advance byte once remaining units fit in one
    assign w_adv_fin    = w_borrow || (w_diff == '0);
    // line step: short forms for |delta| <= 64
    assign w_pos_small  = !w_borrow && (w_diff <= 32'(SHORT_MAX));
    assign w_neg_small  = w_borrow && (w_diff >= 32'(-SHORT_MAX));

    always_comb begin
        unique case (r_idx)
            3'd0:    w_long_byte = 8'(LONG_ESC);
            3'd1:    w_long_byte = r_delta[31:24];
            3'd2:    w_long_byte = r_delta[23:16];
            3'd3:    w_long_byte = r_delta[15:8];
            3'd4:    w_long_byte = r_delta[7:0];
            default: w_long_byte = 8'(LONG_ESC);
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_odd       = r_odd;
        n_text_base = r_text_base;
        n_prev_pc   = r_prev_pc;
        n_prev_line = r_prev_line;
        n_pc        = r_pc;
        n_line      = r_line;
        n_units     = r_units;
        n_ovf       = r_ovf;
        n_delta     = r_delta;
        n_long      = r_long;
        n_short     = r_short;
        n_idx       = r_idx;
        n_m_data    = r_m_data;
        n_m_last    = r_m_last;
        n_m_user    = r_m_user;
        w_push      = 1'b0;

        if (i_cfg_we) begin
            n_text_base = i_cfg_wdata;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_pc   = w_in_pc;
                    n_line = w_in_line;
                    unique case (w_req)
                        REQ_START: begin
                            n_prev_pc   = r_text_base;
                            n_prev_line = '0;
                            n_odd       = 1'b0;
                        end
                        REQ_RECORD: begin
                            if (!w_in_skip && (w_in_line != r_prev_line)) begin
                                n_state = ST_PCDIFF;
                            end
                        end
                        REQ_FINISH: begin
                            if (r_odd) begin
                                n_state = ST_PAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_PCDIFF: begin
                n_ovf = w_adv_ovf;
                if (w_borrow || w_adv_ovf) begin
                    n_units = '0;
                    n_state = ST_LDELTA;
                end else begin
                    n_units = w_units_full[ADV_W-1:0];
                    n_state = (w_units_full == '0) ? ST_LDELTA : ST_ADV;
                end
            end
            ST_ADV: begin
                if (w_slot) begin
                    w_push   = 1'b1;
                    n_m_last = 1'b0;
                    n_m_user = r_ovf;
                    if (w_adv_fin) begin
                        n_m_data = 8'(ADV_BASE) + r_units[7:0];
                        n_units  = '0;
                        n_state  = ST_LDELTA;
                    end else begin
                        n_m_data = 8'(ADV_BASE + ADV_STEP);
                        n_units  = w_diff[ADV_W-1:0];
                    end
                end
            end
            ST_LDELTA: begin
                n_delta     = w_diff;
                n_long      = !(w_pos_small || w_neg_small);
                n_short     = w_pos_small ? w_diff[7:0] : 8'(SHORT_MAX) - w_diff[7:0];
                n_idx       = '0;
                n_prev_line = r_line;
                n_prev_pc   = r_pc + 32'(MIN_INSTR_BYTES);
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_slot) begin
                    w_push   = 1'b1;
                    n_m_user = r_ovf;
                    if (!r_long) begin
                        n_m_data = r_short;
                        n_m_last = 1'b1;
                        n_state  = ST_IDLE;
                    end else begin
                        n_m_data = w_long_byte;
                        n_m_last = (r_idx == 3'd4);
                        n_idx    = r_idx + 3'd1;
                        if (r_idx == 3'd4) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_PAD: begin
                if (w_slot) begin
                    w_push   = 1'b1;
                    n_m_data = 8'(PAD_BYTE);
                    n_m_last = 1'b1;
                    n_m_user = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // every emitted byte flips parity; padding brings it back to even
        if (w_push) begin
            n_odd = !n_odd;
        end

        if (w_push) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_m_valid   <= 1'b0;
            r_odd       <= 1'b0;
            r_text_base <= '0;
            r_prev_pc   <= '0;
            r_prev_line <= '0;
        end else begin
            r_state     <= n_state;
            r_m_valid   <= n_m_valid;
            r_odd       <= n_odd;
            r_text_base <= n_text_base;
            r_prev_pc   <= n_prev_pc;
            r_prev_line <= n_prev_line;
        end
        r_pc     <= n_pc;
        r_line   <= n_line;
        r_units  <= n_units;
        r_ovf    <= n_ovf;
        r_delta  <= n_delta;
        r_long   <= n_long;
        r_short  <= n_short;
        r_idx    <= n_idx;
        r_m_data <= n_m_data;
        r_m_last <= n_m_last;
        r_m_user <= n_m_user;
    end

endmodule

`default_nettype wire

// ===== rtl/plte_checker.sv =====
`default_nettype none

`include "pc_line_table_encoder_assert.svh"

module plte_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_s_tvalid,
    input wire logic       o_s_tready,
    input wire logic [1:0] i_s_tuser,
    input wire logic       o_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] o_m_tdata,
    input wire logic       o_m_tlast,
    input wire logic       o_m_tuser
);

    import plte_pkg::*;

    // stalled byte holds
    `PLTE_ASSERT_NXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser), "output byte changed under stall")

    // a start item never occupies the sequencer
    `PLTE_ASSERT_NXT(a_start_ready, i_s_tvalid && o_s_tready && i_s_tuser == REQ_START, o_s_tready, "ready dropped after start item")

    // a pending byte with no ready cannot vanish while input is blocked
    `PLTE_ASSERT_IMP(a_busy_or_out, !o_s_tready && !o_m_tvalid && $past(o_m_tvalid) && !$past(i_m_tready), 1'b0, "output byte lost")

    // reset empties the output register
    `PLTE_ASSERT_RST(a_rst_empty, !i_rst_n, !o_m_tvalid, "output valid after reset")

endmodule

bind pc_line_table_encoder plte_checker u_plte_checker (.*);

`default_nettype wire
